// File: hw/rtl/lurf_pkg.sv
// Shared types and defaults for the longest unique run finder.
// No dependencies; lurf_scan and the top level in hw/rtl import this package.
`timescale 1ns / 1ps

package lurf_pkg;

    localparam int CHAR_W   = 8;
    localparam int START_W  = 16;
    localparam int LENGTH_W = 17;

    localparam longint unsigned DEF_MAX_LEN  = 64'd65536;
    localparam int              DEF_ALPHABET = 256;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              is_last;
    } byte_t;

    typedef struct packed {
        logic [START_W-1:0]  best_start;
        logic [LENGTH_W-1:0] best_length;
        logic                overflow;
    } result_t;

endpackage

// File: hw/rtl/lurf_pos_ram.sv
// Last-position table: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module lurf_pos_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/lurf_scan.sv
// Window tracker: seen marks, window start, best run and the result register.
// Depends on lurf_pkg; takes table read data from lurf_pos_ram.
`timescale 1ns / 1ps

module lurf_scan #(
    parameter longint unsigned MAX_LEN  = lurf_pkg::DEF_MAX_LEN,
    parameter int              ALPHABET = lurf_pkg::DEF_ALPHABET,
    parameter int              SW       = 8,
    parameter int              PW       = 16,
    parameter int              CW       = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              s1_valid,
    input  logic [SW-1:0]     s1_sym,
    input  logic              s1_last,
    input  logic [PW-1:0]     rd_pos,
    input  logic              hit,
    input  logic [PW-1:0]     hit_pos,
    input  logic              result_stall,
    output logic              wr_en,
    output logic [SW-1:0]     wr_addr,
    output logic [PW-1:0]     wr_pos,
    output logic              result_valid,
    output lurf_pkg::result_t result_data
);

    import lurf_pkg::*;

    logic [ALPHABET-1:0] seen_reg;
    logic [ALPHABET-1:0] seen_next;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       pos_next;
    logic [PW-1:0]       ws_reg;
    logic [PW-1:0]       ws_next;
    logic [PW-1:0]       bs_reg;
    logic [PW-1:0]       bs_next;
    logic [CW-1:0]       bl_reg;
    logic [CW-1:0]       bl_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    result_t             res_data_reg;
    result_t             res_data_next;

    logic          commit;
    logic          full;
    logic [PW-1:0] prev;
    logic [PW-1:0] ws_upd;
    logic [CW-1:0] run;
    logic [PW-1:0] bs_upd;
    logic [CW-1:0] bl_upd;
    logic          ovf_upd;

    assign commit = s1_valid && en;
    assign full   = (pos_reg >= CW'(MAX_LEN));
    assign prev   = hit ? hit_pos : rd_pos;

    always_comb
    begin
        ws_upd = ws_reg;
        if (seen_reg[s1_sym] && (prev >= ws_reg))
        begin
            ws_upd = PW'(prev + PW'(1));
        end
        run    = pos_reg - CW'(ws_upd) + CW'(1);
        bs_upd = bs_reg;
        bl_upd = bl_reg;
        if (!full && (run > bl_reg))
        begin
            bs_upd = ws_upd;
            bl_upd = run;
        end
        ovf_upd = ovf_reg || full;
    end

    assign wr_en   = commit && !full;
    assign wr_addr = s1_sym;
    assign wr_pos  = PW'(pos_reg);

    always_comb
    begin
        seen_next                 = seen_reg;
        pos_next                  = pos_reg;
        ws_next                   = ws_reg;
        bs_next                   = bs_reg;
        bl_next                   = bl_reg;
        ovf_next                  = ovf_reg;
        res_valid_next            = res_valid_reg && result_stall;
        res_data_next             = res_data_reg;
        if (commit)
        begin
            if (s1_last)
            begin
                seen_next                 = '0;
                pos_next                  = '0;
                ws_next                   = '0;
                bs_next                   = '0;
                bl_next                   = '0;
                ovf_next                  = 1'b0;
                res_valid_next            = 1'b1;
                res_data_next.best_start  = START_W'(bs_upd);
                res_data_next.best_length = LENGTH_W'(bl_upd);
                res_data_next.overflow    = ovf_upd;
            end
            else
            begin
                ovf_next = ovf_upd;
                if (!full)
                begin
                    seen_next[s1_sym] = 1'b1;
                    pos_next          = pos_reg + CW'(1);
                    ws_next           = ws_upd;
                    bs_next           = bs_upd;
                    bl_next           = bl_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            pos_reg       <= '0;
            ws_reg        <= '0;
            bs_reg        <= '0;
            bl_reg        <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            ws_reg        <= ws_next;
            bs_reg        <= bs_next;
            bl_reg        <= bl_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

endmodule

// File: hw/rtl/longest_unique_run_finder_top.sv
// Longest run of distinct bytes in a byte stream, one byte per transfer.
// A final byte passes the input stage register, then the result register.
// Throughput: one byte per cycle while byte_stall is low, set by one
// read and one write of the last-position table per byte, with forwarding
// between adjacent bytes. Reset: control and seen marks clear at once;
// the table is not cleared and serves only values seen in the string.
`timescale 1ns / 1ps

module longest_unique_run_finder_top #(
    parameter longint unsigned MAX_LEN  = lurf_pkg::DEF_MAX_LEN,
    parameter int              ALPHABET = lurf_pkg::DEF_ALPHABET
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  lurf_pkg::byte_t   byte_data,
    output logic              result_valid,
    input  logic              result_stall,
    output lurf_pkg::result_t result_data
);

    import lurf_pkg::*;

    localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int PW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 64'd1);

    logic          en;
    logic [16:0]   red;
    logic [SW-1:0] sym_in;

    logic          s1_valid_reg;
    logic [SW-1:0] s1_sym_reg;
    logic          s1_last_reg;
    logic          hit_reg;
    logic [PW-1:0] hit_pos_reg;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [PW-1:0] wr_pos;
    logic [PW-1:0] rd_pos;

    // reduce the byte into the alphabet by shifted compare and subtract
    always_comb
    begin
        red = {9'd0, byte_data.char_byte};
        for (int k = 7; k >= 0; k--)
        begin
            if (red >= (17'(ALPHABET) << k))
            begin
                red = red - (17'(ALPHABET) << k);
            end
        end
    end

    assign sym_in = red[SW-1:0];

    // hold only while a final byte waits for the result register
    assign en         = !(s1_valid_reg && s1_last_reg && result_valid && result_stall);
    assign byte_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= byte_valid;
            s1_last_reg  <= byte_data.is_last;
            hit_reg      <= wr_en && (wr_addr == sym_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sym_reg  <= sym_in;
            hit_pos_reg <= wr_pos;
        end
    end

    lurf_pos_ram #(
        .DEPTH (ALPHABET),
        .AW    (SW),
        .DW    (PW)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_pos),
        .rd_en   (en),
        .rd_addr (sym_in),
        .rd_data (rd_pos)
    );

    lurf_scan #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET),
        .SW       (SW),
        .PW       (PW),
        .CW       (CW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .s1_valid     (s1_valid_reg),
        .s1_sym       (s1_sym_reg),
        .s1_last      (s1_last_reg),
        .rd_pos       (rd_pos),
        .hit          (hit_reg),
        .hit_pos      (hit_pos_reg),
        .result_stall (result_stall),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_pos       (wr_pos),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for longest_unique_run_finder_top: drives byte strings,
// predicts the best distinct-byte run per string and checks every result transfer.
// Depends on lurf_pkg and the top-level RTL in hw/rtl.
`timescale 1ns / 1ps

module tb_top;

    import lurf_pkg::*;

    localparam longint unsigned RUN_MAX_LEN  = DEF_MAX_LEN;
    localparam int              RUN_ALPHABET = DEF_ALPHABET;
    localparam int              RANDOM_ITEMS = 1050;
    localparam int              IDLE_LIMIT   = 5000;
    localparam int              TAIL_CYCLES  = 10;

    typedef struct {
        byte_t data;
        bit    drain;
    } pending_byte_t;

    logic    clk;
    logic    rst_n;
    logic    byte_valid;
    logic    byte_stall;
    byte_t   byte_data;
    logic    result_valid;
    logic    result_stall;
    result_t result_data;

    pending_byte_t pending_bytes[$];
    result_t       expected_reports[$];

    longint unsigned pos_table [RUN_ALPHABET];
    bit              seen_tbl  [RUN_ALPHABET];
    longint unsigned next_pos;
    longint unsigned win_lo;
    longint unsigned top_start;
    longint unsigned top_len;
    bit              too_long;

    int fails;
    int idle_cycles;
    bit byte_took;
    int gap_left;
    int burst_left;
    int stall_cycle;
    int stall_run;

    longest_unique_run_finder_top #(
        .MAX_LEN  (RUN_MAX_LEN),
        .ALPHABET (RUN_ALPHABET)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_string();
        for (int i = 0; i < RUN_ALPHABET; i++)
        begin
            seen_tbl[i] = 1'b0;
        end
        next_pos  = 0;
        win_lo    = 0;
        top_start = 0;
        top_len   = 0;
        too_long  = 1'b0;
    endfunction

    function automatic void track_byte(input byte_t b);
        int unsigned     sym;
        longint unsigned run_len;
        result_t         r;
        sym = int'(b.char_byte) % RUN_ALPHABET;
        if (next_pos >= RUN_MAX_LEN)
        begin
            too_long = 1'b1;
        end
        else
        begin
            if (seen_tbl[sym] && pos_table[sym] >= win_lo)
            begin
                win_lo = pos_table[sym] + 1;
            end
            pos_table[sym] = next_pos;
            seen_tbl[sym]  = 1'b1;
            run_len = next_pos - win_lo + 1;
            if (run_len > top_len)
            begin
                top_len   = run_len;
                top_start = win_lo;
            end
            next_pos = next_pos + 1;
        end
        if (b.is_last)
        begin
            r.best_start  = top_start[START_W-1:0];
            r.best_length = top_len[LENGTH_W-1:0];
            r.overflow    = too_long;
            expected_reports.push_back(r);
            clear_string();
        end
    endfunction

    function automatic void add_byte(input logic [CHAR_W-1:0] ch, input bit last,
                                     input bit drain);
        pending_byte_t p;
        p.data.char_byte = ch;
        p.data.is_last   = last;
        p.drain          = drain;
        pending_bytes.push_back(p);
    endfunction

    function automatic void add_text(input string s, input bit drain);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i], i == s.len() - 1, drain && i == 0);
        end
    endfunction

    // Driver: bursts of transfers separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else if (!byte_valid || byte_took)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                byte_valid <= 1'b0;
            end
            else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain && expected_reports.size() != 0))
            begin
                byte_valid <= 1'b0;
            end
            else
            begin
                byte_valid <= 1'b1;
                byte_data  <= pending_bytes[0].data;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // Receiver stall: free flow, random, then long stall runs, in turn.
    always @(negedge clk)
    begin
        stall_cycle = stall_cycle + 1;
        case ((stall_cycle / 300) % 3)
            0: result_stall <= 1'b0;
            1: result_stall <= $urandom_range(0, 1);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run = stall_run - 1;
                    result_stall <= 1'b1;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_run = $urandom_range(1, 20);
                    result_stall <= 1'b1;
                end
                else
                begin
                    result_stall <= 1'b0;
                end
            end
        endcase
    end

    // Monitor: predict on accepted bytes, check accepted results, watch for hangs.
    always @(posedge clk)
    begin
        result_t want;
        byte_took = rst_n && byte_valid && !byte_stall;
        if (byte_took)
        begin
            track_byte(pending_bytes[0].data);
            void'(pending_bytes.pop_front());
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result_data: unexpected transfer, actual %h", result_data);
                fails = fails + 1;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (result_data.best_start !== want.best_start)
                begin
                    $error("best_start: expected %0d, actual %0d",
                           want.best_start, result_data.best_start);
                    fails = fails + 1;
                end
                if (result_data.best_length !== want.best_length)
                begin
                    $error("best_length: expected %0d, actual %0d",
                           want.best_length, result_data.best_length);
                    fails = fails + 1;
                end
                if (result_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d",
                           want.overflow, result_data.overflow);
                    fails = fails + 1;
                end
            end
        end
        if (byte_took || (rst_n && result_valid && !result_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int              random_count;
        int              len;
        int              span;
        int              base;
        int              j;
        bit              drain;
        logic [CHAR_W-1:0] perm [256];
        logic [CHAR_W-1:0] tmp;

        clk          = 1'b0;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_data    = '0;
        result_stall = 1'b0;
        fails        = 0;
        idle_cycles  = 0;
        byte_took    = 1'b0;
        gap_left     = 0;
        burst_left   = 1;
        stall_cycle  = 0;
        stall_run    = 0;
        next_pos     = 0;
        for (int i = 0; i < RUN_ALPHABET; i++)
        begin
            pos_table[i] = 0;
        end
        clear_string();

        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_text("abcabcbb", 1'b0);
        add_text("bbb", 1'b0);
        add_text("abba", 1'b0);
        add_text("dvdf", 1'b0);

        // Every byte value once, twice over: longest possible run and a tie.
        for (int i = 0; i < 256; i++)
        begin
            perm[i] = i[CHAR_W-1:0];
        end
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < 512; i++)
        begin
            add_byte(perm[i % 256], i == 511, 1'b0);
        end

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            len   = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 320)
                                                 : $urandom_range(1, 32);
            span  = 1 << $urandom_range(0, 8);
            base  = $urandom_range(0, 255);
            drain = (random_count == 0) || ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++)
            begin
                add_byte(8'((base + $urandom_range(0, span - 1)) % 256), i == len - 1,
                         drain && i == 0);
            end
            random_count = random_count + len;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fails == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lurf_pkg.sv
hw/rtl/lurf_pos_ram.sv
hw/rtl/lurf_scan.sv
hw/rtl/longest_unique_run_finder_top.sv
tb/tb_top.sv
